/* rtl/core/zone_valve_pump_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// zone_valve_pump_sequencer_defines
// Assertion macros shared by the zone valve and pump sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ZONE_VALVE_PUMP_SEQUENCER_DEFINES_SVH
`define ZONE_VALVE_PUMP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ZVP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zvp same-cycle check failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ZVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zvp next-cycle check failed");

`endif

/* rtl/core/zvp_pkg.sv */
// ----------------------------------------------------------------------------
// zvp_pkg
// Types, widths and command codes of the zone valve and pump sequencer.
// ----------------------------------------------------------------------------
package zvp_pkg;

  localparam int CMD_W          = 3;
  localparam int ZONE_W         = 3;
  localparam int MASK_W         = 6;
  localparam int GRACE_W        = 24;
  localparam int ZONE_COUNT_DEF = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_ZONE_ON  = 3'd1,
    CMD_ZONE_OFF = 3'd2,
    CMD_ZONE_NOW = 3'd3,
    CMD_PUMP_ON  = 3'd4,
    CMD_ALL_OFF  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [MASK_W-1:0] valve_drive;
    logic              pump_drive;
    logic              grace_pending;
    logic              any_zone_on;
  } status_t;

endpackage

/* rtl/core/zvp_if.sv */
// ----------------------------------------------------------------------------
// zvp_if
// Valid/ready channels of the sequencer: commands, status and configuration.
// ----------------------------------------------------------------------------
interface zvp_cmd_if;
  import zvp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ZONE_W-1:0] zone;
  modport source (output valid, command, zone, input ready);
  modport sink (input valid, command, zone, output ready);
endinterface

interface zvp_status_if;
  import zvp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] valve_drive;
  logic              pump_drive;
  logic              grace_pending;
  logic              any_zone_on;
  modport source (output valid, valve_drive, pump_drive, grace_pending, any_zone_on,
                  input ready);
  modport sink (input valid, valve_drive, pump_drive, grace_pending, any_zone_on,
                output ready);
endinterface

interface zvp_cfg_if;
  import zvp_pkg::*;
  logic               valid;
  logic               ready;
  logic [GRACE_W-1:0] grace_ticks;
  modport source (output valid, grace_ticks, input ready);
  modport sink (input valid, grace_ticks, output ready);
endinterface

/* rtl/core/zone_valve_pump_sequencer.sv */
// ----------------------------------------------------------------------------
// zone_valve_pump_sequencer
// Drives zone valve relays and a shared pump from a stream of commands.
// ----------------------------------------------------------------------------
// Commands (tick, zone on, zone off, zone off now, pump on, all off) arrive
// on cmd_ch with a zone index. Every command yields one status transfer on
// status_ch: the valve mask, the pump relay, the grace flag and a flag for
// any open zone, all as they stand after that command.
// A command is taken into an input register; when it advances, the state is
// updated and the status is loaded into the output register, from which it
// transfers on status_ch. One command is taken every cycle while the
// receiver keeps up; the single state update per cycle sets that rate.
// When the receiver stalls, the status waits in the output register and one
// more command can sit in the input register; cmd_ch.ready drops only when
// both are full and the receiver is stalling.
// The cfg channel writes grace_ticks, the number of ticks the last valve and
// the pump stay on after the last zone is switched off; it is always ready.
// Reset (rst, synchronous) closes all valves, stops the pump, clears the
// grace timer and grace_ticks, and empties both registers.
// ----------------------------------------------------------------------------
module zone_valve_pump_sequencer #(
  parameter int ZONE_COUNT = zvp_pkg::ZONE_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  zvp_cmd_if.sink      cmd_ch,
  zvp_status_if.source status_ch,
  zvp_cfg_if.sink      cfg
);
  import zvp_pkg::*;

  logic               s1_valid;
  logic [CMD_W-1:0]   s1_command;
  logic [ZONE_W-1:0]  s1_zone;
  logic               out_valid;
  status_t            out_status;
  status_t            status_next;
  logic [GRACE_W-1:0] grace_ticks;
  logic               advance;

  assign advance      = s1_valid && (!out_valid || status_ch.ready);
  assign cmd_ch.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      s1_valid <= cmd_ch.valid;
    end
    if (cmd_ch.valid && cmd_ch.ready) begin
      s1_command <= cmd_ch.command;
      s1_zone    <= cmd_ch.zone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grace_ticks <= '0;
    end else if (cfg.valid) begin
      grace_ticks <= cfg.grace_ticks;
    end
  end

  zvp_state #(
    .ZONE_COUNT(ZONE_COUNT)
  ) u_state (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .command    (cmd_e'(s1_command)),
    .zone       (s1_zone),
    .grace_ticks(grace_ticks),
    .status_next(status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_status <= status_next;
    end
  end

  assign status_ch.valid         = out_valid;
  assign status_ch.valve_drive   = out_status.valve_drive;
  assign status_ch.pump_drive    = out_status.pump_drive;
  assign status_ch.grace_pending = out_status.grace_pending;
  assign status_ch.any_zone_on   = out_status.any_zone_on;

endmodule

/* rtl/core/zvp_state.sv */
// ----------------------------------------------------------------------------
// zvp_state
// Zone mask, pump flag and grace timer, updated by one command per step.
// ----------------------------------------------------------------------------
`include "zone_valve_pump_sequencer_defines.svh"

module zvp_state #(
  parameter int ZONE_COUNT = zvp_pkg::ZONE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  zvp_pkg::cmd_e               command,
  input  logic [zvp_pkg::ZONE_W-1:0]  zone,
  input  logic [zvp_pkg::GRACE_W-1:0] grace_ticks,
  output zvp_pkg::status_t            status_next
);
  import zvp_pkg::*;

  localparam int ZONE_LIMIT = (ZONE_COUNT < MASK_W) ? ZONE_COUNT : MASK_W;

  logic [MASK_W-1:0]  mask, mask_next;
  logic               pump, pump_next;
  logic               grace, grace_next;
  logic [ZONE_W-1:0]  grace_zone, grace_zone_next;
  logic [GRACE_W-1:0] remaining, remaining_next;

  logic               zone_ok;
  logic [MASK_W-1:0]  zone_bit;
  logic [MASK_W-1:0]  held_bit;
  logic [MASK_W-1:0]  held_clear;
  logic [GRACE_W-1:0] remaining_dec;
  logic               several_on;

  assign zone_ok       = 32'(zone) < ZONE_LIMIT;
  assign zone_bit      = MASK_W'(1) << zone;
  assign held_bit      = MASK_W'(1) << grace_zone;
  // Ending a grace period drops the valve that was being held open.
  assign held_clear    = grace ? ~held_bit : '1;
  assign remaining_dec = (remaining != '0) ? remaining - GRACE_W'(1) : '0;
  assign several_on    = (mask & (mask - MASK_W'(1))) != '0;

  always_comb begin
    mask_next       = mask;
    pump_next       = pump;
    grace_next      = grace;
    grace_zone_next = grace_zone;
    remaining_next  = remaining;
    case (command)
      CMD_TICK: begin
        if (grace) begin
          remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            mask_next  = mask & ~held_bit;
            grace_next = 1'b0;
            pump_next  = 1'b0;
          end
        end
      end
      CMD_ZONE_ON: begin
        if (zone_ok) begin
          if (grace && grace_zone == zone) begin
            grace_next     = 1'b0;
            remaining_next = '0;
          end else if ((mask & zone_bit) == '0) begin
            mask_next      = (mask & held_clear) | zone_bit;
            grace_next     = 1'b0;
            remaining_next = '0;
            pump_next      = 1'b1;
          end
        end
      end
      CMD_ZONE_OFF: begin
        if (zone_ok && (mask & zone_bit) != '0) begin
          if (several_on) begin
            mask_next = mask & ~zone_bit;
          end else begin
            grace_next      = 1'b1;
            grace_zone_next = zone;
            remaining_next  = grace_ticks;
          end
        end
      end
      CMD_ZONE_NOW: begin
        if (zone_ok && (mask & zone_bit) != '0) begin
          mask_next      = mask & ~zone_bit & held_clear;
          grace_next     = 1'b0;
          remaining_next = '0;
          if ((mask & ~zone_bit & held_clear) == '0) begin
            pump_next = 1'b0;
          end
        end
      end
      CMD_PUMP_ON: begin
        pump_next = 1'b1;
      end
      CMD_ALL_OFF: begin
        mask_next      = '0;
        grace_next     = 1'b0;
        remaining_next = '0;
        pump_next      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign status_next.valve_drive   = mask_next;
  assign status_next.pump_drive    = pump_next;
  assign status_next.grace_pending = grace_next;
  assign status_next.any_zone_on   = mask_next != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      pump       <= 1'b0;
      grace      <= 1'b0;
      grace_zone <= '0;
      remaining  <= '0;
    end else if (step) begin
      mask       <= mask_next;
      pump       <= pump_next;
      grace      <= grace_next;
      grace_zone <= grace_zone_next;
      remaining  <= remaining_next;
    end
  end

  // While a grace period runs, only the held zone is open.
  `ZVP_ASSERT_NOW(a_grace_one_zone, grace, $onehot(mask) && mask == held_bit)
  `ZVP_ASSERT_NOW(a_zone_needs_pump, mask != '0, pump)
  `ZVP_ASSERT_NOW(a_grace_needs_pump, grace, pump)
  `ZVP_ASSERT_NEXT(a_pump_on_cmd, step && command == CMD_PUMP_ON, pump)

endmodule

/* tb/sv/zvp_status_check.sv */
// ----------------------------------------------------------------------------
// zvp_status_check
// Watches the command, status and configuration channels of the zone valve
// and pump sequencer. It keeps its own copy of the zone mask, pump flag and
// grace timer, and queues the status each accepted command should give.
// Each status transfer is compared field by field with the oldest entry in
// that queue. The number of open expectations and failures goes to the top.
// ----------------------------------------------------------------------------
module zvp_status_check #(
  parameter int ZONE_COUNT = zvp_pkg::ZONE_COUNT_DEF
) (
  input  logic   clk,
  input  logic   rst,
  zvp_cmd_if     cmd_ch,
  zvp_status_if  status_ch,
  zvp_cfg_if     cfg,
  output int     pending,
  output int     fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import zvp_pkg::*;

  // The mask is six bits wide, so zones above five never count.
  localparam int ZONE_LIMIT = (ZONE_COUNT < MASK_W) ? ZONE_COUNT : MASK_W;

  logic [MASK_W-1:0]  open_zones;
  logic               pump_on;
  logic               hold_active;
  logic [ZONE_W-1:0]  hold_zone;
  logic [GRACE_W-1:0] hold_left;
  logic [GRACE_W-1:0] hold_ticks;
  status_t            status_q[$];

  // Ends a grace period, closing the valve that was held open for it.
  function void drop_hold();
    if (hold_active) begin
      open_zones[hold_zone] = 1'b0;
      hold_active = 1'b0;
      hold_left = '0;
    end
  endfunction

  function status_t apply_command(logic [CMD_W-1:0] code, logic [ZONE_W-1:0] zn);
    status_t s;
    logic    zone_ok;
    zone_ok = (zn < ZONE_LIMIT);
    case (code)
      CMD_TICK: begin
        if (hold_active) begin
          if (hold_left != 0) hold_left = hold_left - 1'b1;
          if (hold_left == 0) begin
            drop_hold();
            pump_on = 1'b0;
          end
        end
      end
      CMD_ZONE_ON: begin
        if (zone_ok) begin
          if (hold_active && hold_zone == zn) begin
            // Reopening the held zone just cancels the pending off.
            hold_active = 1'b0;
            hold_left = '0;
          end else if (!open_zones[zn]) begin
            drop_hold();
            open_zones[zn] = 1'b1;
            pump_on = 1'b1;
          end
        end
      end
      CMD_ZONE_OFF: begin
        if (zone_ok && open_zones[zn]) begin
          if ($countones(open_zones) > 1) begin
            open_zones[zn] = 1'b0;
          end else begin
            hold_active = 1'b1;
            hold_zone = zn;
            hold_left = hold_ticks;
          end
        end
      end
      CMD_ZONE_NOW: begin
        if (zone_ok && open_zones[zn]) begin
          open_zones[zn] = 1'b0;
          drop_hold();
          if (open_zones == 0) pump_on = 1'b0;
        end
      end
      CMD_PUMP_ON: begin
        pump_on = 1'b1;
      end
      CMD_ALL_OFF: begin
        open_zones = '0;
        hold_active = 1'b0;
        hold_left = '0;
        pump_on = 1'b0;
      end
      default: begin
      end
    endcase
    s.valve_drive = open_zones;
    s.pump_drive = pump_on;
    s.grace_pending = hold_active;
    s.any_zone_on = |open_zones;
    return s;
  endfunction

  task automatic check_field(string label, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      open_zones = '0;
      pump_on = 1'b0;
      hold_active = 1'b0;
      hold_zone = '0;
      hold_left = '0;
      hold_ticks = '0;
      status_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) hold_ticks = cfg.grace_ticks;
      if (cmd_ch.valid && cmd_ch.ready) begin
        status_q.push_back(apply_command(cmd_ch.command, cmd_ch.zone));
      end
      if (status_ch.valid && status_ch.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: status transfer with nothing expected, valve %0h pump %0d",
                   $time, status_ch.valve_drive, status_ch.pump_drive);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("valve_drive", want.valve_drive, status_ch.valve_drive);
          check_field("pump_drive", want.pump_drive, status_ch.pump_drive);
          check_field("grace_pending", want.grace_pending, status_ch.grace_pending);
          check_field("any_zone_on", want.any_zone_on, status_ch.any_zone_on);
        end
      end
    end
    pending = status_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the zone valve and pump sequencer with a directed command sequence
// and then long runs of random zone scenarios under several grace settings
// and stall patterns. A separate monitor predicts and checks every status.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import zvp_pkg::*;

  // Command codes the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [GRACE_W-1:0] GRACE_MAX = '1;

  logic clk;
  logic rst;
  int   pending;
  int   fail_count;
  int   src_idle;
  int   sink_idle;

  zvp_cmd_if    cmd_if ();
  zvp_status_if status_if ();
  zvp_cfg_if    cfg_if ();

  zone_valve_pump_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_if),
    .status_ch (status_if),
    .cfg       (cfg_if)
  );

  zvp_status_check status_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_ch     (cmd_if),
    .status_ch  (status_if),
    .cfg        (cfg_if),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Status receiver: stalls at random at the current rate.
  initial begin
    status_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      status_if.ready = ($urandom_range(99) >= sink_idle);
    end
  end

  task automatic send(input logic [CMD_W-1:0] code, input logic [ZONE_W-1:0] zn);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      cmd_if.valid = 1'b0;
    end
    @(negedge clk);
    cmd_if.valid = 1'b1;
    cmd_if.command = code;
    cmd_if.zone = zn;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  // Stops sending and waits until every status has come back.
  task automatic settle();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_grace(input logic [GRACE_W-1:0] value);
    settle();
    cfg_if.valid = 1'b1;
    cfg_if.grace_ticks = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Commands mostly aim at one or two zones so that grace periods start,
  // restart, get cancelled and expire often.
  task automatic random_run(input int count);
    logic [ZONE_W-1:0] focus_a;
    logic [ZONE_W-1:0] focus_b;
    logic [ZONE_W-1:0] zn;
    logic [CMD_W-1:0]  code;
    int                pick;
    int                zpick;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        focus_a = ZONE_W'($urandom_range(5));
        focus_b = ZONE_W'($urandom_range(5));
      end
      pick = $urandom_range(99);
      if (pick < 35) code = CMD_TICK;
      else if (pick < 57) code = CMD_ZONE_ON;
      else if (pick < 79) code = CMD_ZONE_OFF;
      else if (pick < 86) code = CMD_ZONE_NOW;
      else if (pick < 91) code = CMD_PUMP_ON;
      else if (pick < 95) code = CMD_ALL_OFF;
      else if (pick < 97) code = CMD_SPARE_LO;
      else code = CMD_SPARE_HI;
      zpick = $urandom_range(99);
      if (zpick < 45) zn = focus_a;
      else if (zpick < 80) zn = focus_b;
      else zn = ZONE_W'($urandom_range(7));
      send(code, zn);
    end
  endtask

  function automatic logic [GRACE_W-1:0] pick_grace();
    int r;
    r = $urandom_range(9);
    if (r < 2) return '0;
    if (r < 4) return GRACE_W'(1);
    if (r < 9) return GRACE_W'($urandom_range(2, 8));
    return GRACE_W'($urandom_range(0, GRACE_MAX));
  endfunction

  initial begin
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_TICK;
    cmd_if.zone = '0;
    cfg_if.valid = 1'b0;
    cfg_if.grace_ticks = '0;
    src_idle = 19;
    sink_idle = 57;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Grace of zero from reset: the held valve drops at the first tick.
    send(CMD_ZONE_ON, 0);
    send(CMD_ZONE_OFF, 0);
    send(CMD_TICK, 0);
    send(CMD_ZONE_ON, 5);
    send(CMD_ZONE_ON, 6);
    send(CMD_ZONE_ON, 7);
    send(CMD_ZONE_OFF, 7);
    send(CMD_SPARE_LO, 5);
    send(CMD_SPARE_HI, 2);
    send(CMD_PUMP_ON, 0);
    send(CMD_ALL_OFF, 0);
    send(CMD_PUMP_ON, 3);
    send(CMD_TICK, 0);

    // Short grace: cancel by reopening, restart by a second off, early end.
    set_grace(2);
    send(CMD_ZONE_ON, 1);
    send(CMD_ZONE_OFF, 1);
    send(CMD_TICK, 0);
    send(CMD_ZONE_ON, 1);
    send(CMD_ZONE_OFF, 1);
    send(CMD_TICK, 0);
    send(CMD_ZONE_OFF, 1);
    send(CMD_TICK, 0);
    send(CMD_ZONE_ON, 2);
    send(CMD_ZONE_ON, 3);
    send(CMD_ZONE_OFF, 4);
    send(CMD_ZONE_NOW, 2);
    send(CMD_ZONE_NOW, 3);
    send(CMD_ZONE_ON, 4);
    send(CMD_ZONE_OFF, 4);
    send(CMD_TICK, 0);
    send(CMD_TICK, 0);

    // Largest grace, then a new setting while that grace is still running.
    set_grace(GRACE_MAX);
    send(CMD_ZONE_ON, 4);
    send(CMD_ZONE_OFF, 4);
    send(CMD_TICK, 0);
    set_grace(1);
    send(CMD_TICK, 0);
    send(CMD_ZONE_NOW, 4);
    send(CMD_ZONE_ON, 5);
    send(CMD_ZONE_OFF, 5);
    send(CMD_ALL_OFF, 0);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle = 57;
        sink_idle = 19;
      end else if (phase == 2) begin
        src_idle = 0;
        sink_idle = 0;
      end
      for (int seg = 0; seg < 4; seg++) begin
        set_grace(pick_grace());
        random_run(160);
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/zvp_pkg.sv
rtl/core/zvp_if.sv
rtl/core/zvp_state.sv
rtl/core/zone_valve_pump_sequencer.sv
tb/sv/zvp_status_check.sv
tb/sv/testbench.sv
